// ===== hdl/egb_pkg.sv =====
// ----------------------------------------------------------------------------
// egb_pkg
// Shared widths, register codes and the job word passed from front to back.
// ----------------------------------------------------------------------------
package egb_pkg;

    localparam int SYM_W       = 8;   // input symbol
    localparam int CFG_W       = 3;   // configuration data
    localparam int CFG_IDX_W   = 1;   // configuration register index
    localparam int CODE_W      = 17;  // longest code word (order 0, symbol 255)
    localparam int LEN_W       = 5;   // code length
    localparam int ACC_W       = 24;  // pending bits plus longest code
    localparam int PEND_W      = 7;   // bits of an unfinished byte
    localparam int PCNT_W      = 3;   // filled positions of an unfinished byte
    localparam int BYTE_W      = 8;
    localparam int BCNT_W      = 4;   // bit_count field
    localparam int NRES_W      = 2;   // bytes per symbol, 0..3
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BCNT_W-1:0] FULL_COUNT = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER_K      = 1'b0,
        CFG_START_OFFSET = 1'b1
    } cfg_reg_t;

    // One packed symbol: up to three bytes to send
    typedef struct packed {
        logic [ACC_W-1:0]  data;      // byte j in data[8j+7:8j]
        logic [NRES_W-1:0] nres;      // number of bytes to send
        logic [BCNT_W-1:0] last_cnt;  // bit_count of the final byte
    } job_t;

endpackage

// ===== hdl/egb_front.sv =====
// ----------------------------------------------------------------------------
// egb_front
// Takes symbols, builds the Exp-Golomb code and packs it onto pending bits.
// ----------------------------------------------------------------------------
module egb_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [egb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [egb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [egb_pkg::SYM_W-1:0]     s_symbol,
    input  logic                          s_last,
    output logic                          job_valid,
    input  logic                          job_ready,
    output egb_pkg::job_t                 job
);
    import egb_pkg::*;

    localparam logic [CODE_W-1:0] ONE_C    = CODE_W'(1);
    localparam logic [LEN_W-1:0]  CODE_W_L = LEN_W'(CODE_W);

    logic [CFG_W-1:0]  order_k_reg;
    logic [CFG_W-1:0]  start_off_reg;

    // stage A: code word, reversed and right aligned
    logic              a_vld_reg;
    logic              a_vld_next;
    logic [CODE_W-1:0] a_rev_reg;
    logic [LEN_W-1:0]  a_len_reg;
    logic              a_last_reg;

    // pending byte state
    logic [PEND_W-1:0] pend_bits_reg;
    logic [PEND_W-1:0] pend_bits_next;
    logic [PCNT_W-1:0] pend_cnt_reg;
    logic [PCNT_W-1:0] pend_cnt_next;
    logic              at_start_reg;
    logic              at_start_next;

    logic              s_fire;
    logic              b_fire;

    logic [8:0]        ge;
    logic [3:0]        grp;
    logic [3:0]        tail_w;
    logic [CODE_W-1:0] sym_ext;
    logic [CODE_W-1:0] base;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] code_rev;
    logic [CODE_W-1:0] code_aln;
    logic [LEN_W-1:0]  len;

    logic [PCNT_W-1:0] cnt0;
    logic [PEND_W-1:0] bits0;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  rest;
    logic [LEN_W-1:0]  total;
    logic [NRES_W-1:0] nfull;
    logic [PCNT_W-1:0] rem;
    logic [NRES_W-1:0] nres;
    logic [BCNT_W-1:0] last_cnt;

    // ---- stage A: group search and code word ----
    always_comb
    begin
        sym_ext = {{(CODE_W-SYM_W){1'b0}}, s_symbol};
        for (int i = 0; i < 9; i++)
        begin
            ge[i] = sym_ext >= (((ONE_C << (i + 1)) - ONE_C) << order_k_reg);
        end
        // thresholds rise with the group, so ge is a thermometer code
        grp    = 4'($countones(ge));
        tail_w = grp + {1'b0, order_k_reg};
        base   = ((ONE_C << grp) - ONE_C) << order_k_reg;
        code   = (ONE_C << tail_w) | (sym_ext - base);
        len    = {grp, 1'b0} + 5'd1 + {2'b00, order_k_reg};
        for (int i = 0; i < CODE_W; i++)
        begin
            code_rev[i] = code[CODE_W-1-i];
        end
        // first code bit lands in bit 0
        code_aln = code_rev >> (CODE_W_L - len);
    end

    // ---- stage B: pack onto pending bits ----
    always_comb
    begin
        cnt0  = at_start_reg ? start_off_reg : pend_cnt_reg;
        bits0 = at_start_reg ? '0 : pend_bits_reg;
        acc   = {{(ACC_W-PEND_W){1'b0}}, bits0}
              | ({{(ACC_W-CODE_W){1'b0}}, a_rev_reg} << cnt0);
        total = {2'b00, cnt0} + a_len_reg;
        nfull = total[4:3];
        rem   = total[2:0];
        rest  = acc >> {nfull, 3'b000};

        if (a_last_reg)
        begin
            nres     = nfull + NRES_W'(rem != '0);
            last_cnt = (rem != '0) ? {1'b0, rem} : FULL_COUNT;
        end
        else
        begin
            nres     = nfull;
            last_cnt = FULL_COUNT;
        end

        job_valid = a_vld_reg && (nres != '0);
        b_fire    = a_vld_reg && (job_ready || (nres == '0));
        s_ready   = !a_vld_reg || b_fire;
        s_fire    = s_valid && s_ready;

        a_vld_next = s_fire ? 1'b1 : (b_fire ? 1'b0 : a_vld_reg);

        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        at_start_next  = at_start_reg;
        if (b_fire)
        begin
            if (a_last_reg)
            begin
                pend_bits_next = '0;
                pend_cnt_next  = '0;
                at_start_next  = 1'b1;
            end
            else
            begin
                pend_bits_next = rest[PEND_W-1:0];
                pend_cnt_next  = rem;
                at_start_next  = 1'b0;
            end
        end
    end

    assign job.data     = acc;
    assign job.nres     = nres;
    assign job.last_cnt = last_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_k_reg   <= '0;
            start_off_reg <= '0;
            a_vld_reg     <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            at_start_reg  <= 1'b1;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_ORDER_K:      order_k_reg   <= cfg_data;
                    CFG_START_OFFSET: start_off_reg <= cfg_data;
                endcase
            end
            a_vld_reg     <= a_vld_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            at_start_reg  <= at_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            a_rev_reg  <= code_aln;
            a_len_reg  <= len;
            a_last_reg <= s_last;
        end
    end

`ifndef NO_ASSERTIONS
    a_stream_restart: assert property (@(posedge clk) disable iff (!rst_n)
        b_fire && a_last_reg |=> at_start_reg && (pend_cnt_reg == '0))
        else $error("stream not restarted after last symbol");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_vld_reg && !b_fire |=> a_vld_reg && $stable(a_rev_reg) && $stable(a_len_reg))
        else $error("stalled code word lost");

    a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> a_vld_reg)
        else $error("accepted symbol not held");
`endif

endmodule

// ===== hdl/egb_fifo.sv =====
// ----------------------------------------------------------------------------
// egb_fifo
// Short job queue between the packing front and the byte sender.
// ----------------------------------------------------------------------------
module egb_fifo
#(
    parameter int DEPTH = egb_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  egb_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output egb_pkg::job_t pop_data
);
    import egb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("queue count out of range");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) || (cnt_reg == FULL_CNT) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");
`endif

endmodule

// ===== hdl/egb_back.sv =====
// ----------------------------------------------------------------------------
// egb_back
// Sends the bytes of each job one per cycle through an output register, while m_ready allows.
// ----------------------------------------------------------------------------
module egb_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  egb_pkg::job_t              pop_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [egb_pkg::BYTE_W-1:0] m_byte,
    output logic [egb_pkg::BCNT_W-1:0] m_count,
    output logic                       m_last
);
    import egb_pkg::*;

    job_t              cur_reg;
    logic              cur_vld_reg;
    logic [NRES_W-1:0] idx_reg;
    logic              out_vld_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BCNT_W-1:0] out_cnt_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              is_final;
    logic              emit;
    logic              take;
    logic [BYTE_W-1:0] byte_sel;

    always_comb
    begin
        out_free  = !out_vld_reg || m_ready;
        is_final  = (idx_reg == cur_reg.nres - 1'b1);
        emit      = cur_vld_reg && out_free;
        pop_ready = !cur_vld_reg || (emit && is_final);
        take      = pop_valid && pop_ready;
        byte_sel  = cur_reg.data[{idx_reg, 3'b000} +: BYTE_W];
    end

    assign m_valid = out_vld_reg;
    assign m_byte  = out_byte_reg;
    assign m_count = out_cnt_reg;
    assign m_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg <= 1'b0;
            idx_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cur_vld_reg <= 1'b1;
                idx_reg     <= '0;
            end
            else if (emit)
            begin
                cur_vld_reg <= !is_final;
                idx_reg     <= idx_reg + 1'b1;
            end

            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= pop_data;
        end
        if (emit)
        begin
            out_byte_reg <= byte_sel;
            out_cnt_reg  <= is_final ? cur_reg.last_cnt : FULL_COUNT;
            out_last_reg <= is_final;
        end
    end

`ifndef NO_ASSERTIONS
    a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_cnt_reg != FULL_COUNT) |-> out_last_reg)
        else $error("partial byte not marked last");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_vld_reg |-> idx_reg < cur_reg.nres)
        else $error("byte index past job end");

    a_job_continues: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !is_final |=> cur_vld_reg)
        else $error("job dropped before its final byte");
`endif

endmodule

// ===== hdl/exp_golomb_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// exp_golomb_byte_encoder
// Order-k Exp-Golomb coder packing code bits LSB first into bytes.
// ----------------------------------------------------------------------------
// A symbol is taken every cycle while the job queue has room; it passes two
// front stages (code word, then packing onto the pending byte) and lands in a
// job queue of JOB_QUEUE_DEPTH entries. The sender gives out one byte per
// cycle while the receiver is ready; a symbol yields the bytes it
// completes plus, on tlast, a flushed partial byte, 0 to 3 in all.
// Sustained throughput is therefore set by the one-byte output channel; the
// first byte passes the code-word register, the job queue, the sender's job
// register and the output register. Configuration writes are taken at once
// (cfg_ready is always high); change them only while the block is idle.
module exp_golomb_byte_encoder
#(
    parameter int JOB_QUEUE_DEPTH = egb_pkg::QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [egb_pkg::CFG_IDX_W-1:0] cfg_index,    // 0 order_k, 1 start_bit_offset
    input  logic [egb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] symbol
    input  logic                          s_axis_tlast,  // last_symbol
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // [7:0] out_byte, [11:8] bit_count
    output logic                          m_axis_tlast   // last_of_run
);
    import egb_pkg::*;

    job_t              push_job;
    job_t              pop_job;
    logic              push_valid;
    logic              push_ready;
    logic              pop_valid;
    logic              pop_ready;
    logic [BYTE_W-1:0] out_byte;
    logic [BCNT_W-1:0] out_cnt;

    assign cfg_ready = 1'b1;

    egb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_symbol  (s_axis_tdata),
        .s_last    (s_axis_tlast),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    egb_fifo
    #(
        .DEPTH (JOB_QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    egb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_job),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_byte    (out_byte),
        .m_count   (out_cnt),
        .m_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_cnt, out_byte};

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream bench for exp_golomb_byte_encoder. Symbols go in on the slave side
// and a predictor packs the same order-k Exp-Golomb codes into bytes. Every
// word from the master side is checked against the oldest predicted byte.
// Runs a directed opening, then random phases with and without idling.
// ----------------------------------------------------------------------------

class egb_scoreboard;

    typedef struct {
        logic [7:0] data;
        logic [3:0] count;
        logic       fin;
    } coded_byte_t;

    coded_byte_t coded_bytes [$];
    int          errors = 0;

    int unsigned order      = 0;
    int unsigned offset     = 0;
    int unsigned pend_bits  = 0;
    int unsigned pend_count = 0;
    bit          new_stream = 1'b1;

    function void set_register(egb_pkg::cfg_reg_t idx, int unsigned val);
        case (idx)
            egb_pkg::CFG_ORDER_K:      order = val & 7;
            egb_pkg::CFG_START_OFFSET: offset = val & 7;
            default: ;
        endcase
    endfunction

    // Packs one symbol onto the pending byte and queues every byte it yields
    function void note_symbol(logic [7:0] sym, logic eos);
        coded_byte_t run [3];
        int unsigned value, grp, len, code, acc, cnt, n, i;
        value = sym;
        if (new_stream)
        begin
            pend_bits  = 0;
            pend_count = offset;
            new_stream = 1'b0;
        end
        grp = 0;
        while (grp < 9 && value >= (((32'd2 << grp) - 1) << order))
            grp++;
        len  = 2 * grp + 1 + order;
        code = (32'd1 << (grp + order)) |
               ((value - (((32'd1 << grp) - 1) << order)) & ((32'd1 << (grp + order)) - 1));
        acc = pend_bits;
        cnt = pend_count;
        n   = 0;
        for (i = 0; i < len; i++)
        begin
            acc |= ((code >> (len - 1 - i)) & 1) << cnt;
            cnt++;
            if (cnt == 8)
            begin
                run[n].data  = 8'(acc);
                run[n].count = 4'd8;
                run[n].fin   = 1'b0;
                n++;
                acc = 0;
                cnt = 0;
            end
        end
        if (eos)
        begin
            if (cnt > 0)
            begin
                run[n].data  = 8'(acc);
                run[n].count = 4'(cnt);
                run[n].fin   = 1'b0;
                n++;
            end
            pend_bits  = 0;
            pend_count = 0;
            new_stream = 1'b1;
        end
        else
        begin
            pend_bits  = acc & 7'h7f;
            pend_count = cnt;
        end
        if (n > 0)
            run[n - 1].fin = 1'b1;
        for (i = 0; i < n; i++)
            coded_bytes.push_back(run[i]);
    endfunction

    function void check_word(logic [15:0] word, logic tlast);
        coded_byte_t want;
        if (coded_bytes.size() == 0)
        begin
            $error("unexpected word: out_byte %02h bit_count %0d last_of_run %0b",
                   word[7:0], word[11:8], tlast);
            errors++;
            return;
        end
        want = coded_bytes.pop_front();
        if (word[7:0] !== want.data)
        begin
            $error("out_byte: expected %02h, got %02h", want.data, word[7:0]);
            errors++;
        end
        if (word[11:8] !== want.count)
        begin
            $error("bit_count: expected %0d, got %0d", want.count, word[11:8]);
            errors++;
        end
        if (tlast !== want.fin)
        begin
            $error("last_of_run: expected %0b, got %0b", want.fin, tlast);
            errors++;
        end
    endfunction

endclass

module tb;

    import egb_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 12;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_ORDER_K;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [7:0] symbol
    logic                 s_axis_tlast  = 1'b0; // last_symbol
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [15:0]          m_axis_tdata;         // [7:0] out_byte, [11:8] bit_count
    logic                 m_axis_tlast;         // last_of_run

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          quiet_cycles   = 0;

    egb_scoreboard sb = new;

    exp_golomb_byte_encoder u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Register write; valid is left high when another write follows at once
    task automatic write_reg(cfg_reg_t idx, int unsigned val, bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, val);
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    task automatic send_symbol(logic [7:0] sym, logic eos);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= eos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_symbol(sym, eos);
    endtask

    // Hold the sender until every predicted word is out, then let the
    // pipeline empty of items that yield nothing
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.coded_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
            3:       begin send_idle_pct = 17; recv_stall_pct = 17; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic random_phase(int mode, int unsigned k, int unsigned off, int items);
        logic [7:0] sym;
        int         i;
        settle();
        write_reg(CFG_ORDER_K, k, 1'b1);
        write_reg(CFG_START_OFFSET, off, 1'b0);
        set_idling(mode);
        for (i = 0; i < items; i++)
        begin
            // short codes are favoured so that several symbols share a byte
            if ($urandom_range(3) == 0)
                sym = 8'($urandom_range(15));
            else
                sym = 8'($urandom_range(255));
            send_symbol(sym, $urandom_range(7) == 0);
        end
    endtask

    // Receiver: checks accepted words and stalls at random
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no word moving on any channel
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int p;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Order 0 at offset 0: shortest and longest codes, single-bit flush
        send_symbol(8'd0, 1'b0);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd1, 1'b0);
        send_symbol(8'd2, 1'b0);
        send_symbol(8'd254, 1'b1);
        send_symbol(8'd0, 1'b1);
        send_symbol(8'd0, 1'b0);

        // Order seven, highest start offset
        settle();
        write_reg(CFG_ORDER_K, 7, 1'b1);
        write_reg(CFG_START_OFFSET, 7, 1'b0);
        send_symbol(8'd127, 1'b1);
        send_symbol(8'd128, 1'b0);
        send_symbol(8'd255, 1'b1);
        send_symbol(8'd0, 1'b0);

        // Offset written mid-stream only counts from the next stream
        settle();
        write_reg(CFG_START_OFFSET, 0, 1'b1);
        write_reg(CFG_ORDER_K, 6, 1'b0);
        send_symbol(8'd64, 1'b1);
        settle();
        write_reg(CFG_ORDER_K, 7, 1'b0);
        // byte-aligned stream: nothing left over to flush
        send_symbol(8'd5, 1'b1);
        send_symbol(8'd100, 1'b0);
        send_symbol(8'd200, 1'b1);

        settle();
        write_reg(CFG_ORDER_K, 3, 1'b1);
        write_reg(CFG_START_OFFSET, 4, 1'b0);
        send_symbol(8'd17, 1'b0);
        send_symbol(8'd170, 1'b0);
        send_symbol(8'd85, 1'b1);

        random_phase(0, 0, 0, 54);
        random_phase(1, 6, 7, 54);
        random_phase(2, 7, 0, 54);
        random_phase(3, $urandom_range(7), $urandom_range(7), 54);
        random_phase(0, $urandom_range(7), $urandom_range(7), 27);
        // sender holds off mid-phase until the output side has caught up
        settle();
        for (p = 0; p < 27; p++)
            send_symbol(8'($urandom_range(255)), $urandom_range(7) == 0);
        random_phase(1, $urandom_range(7), $urandom_range(7), 54);
        random_phase(2, 0, 7, 54);
        random_phase(3, 6, 0, 54);

        settle();
        if (sb.coded_bytes.size() != 0)
        begin
            $error("%0d expected words never arrived", sb.coded_bytes.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/egb_pkg.sv
hdl/egb_front.sv
hdl/egb_fifo.sv
hdl/egb_back.sv
hdl/exp_golomb_byte_encoder.sv
bench/tb.sv
